### rtl/core/ffpba_pkg.sv
// ----------------------------------------------------------------------------
// ffpba_pkg
// Shared types and constants for the first-fit page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffpba_pkg;
   localparam int NUM_PAGES  = 1048576;
   localparam int WORD_BITS  = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int COUNT_W    = 21;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [COUNT_W-1:0]  page_count;
      logic [31:0]         free_address;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] alloc_address;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_MARK_RD, ST_MARK_WR,
      ST_FREE_RD, ST_FREE_WR, ST_RESP
   } state_type;
endpackage
`default_nettype wire

### rtl/core/ffpba_if.sv
// ----------------------------------------------------------------------------
// ffpba_req_if / ffpba_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none
interface ffpba_req_if;
   logic                valid;
   logic                ready;
   ffpba_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ffpba_rsp_if;
   logic                valid;
   logic                ready;
   ffpba_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/first_fit_page_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_page_bitmap_allocator_core
// First-fit page run allocator over a one-bit-per-page bitmap memory.
// ----------------------------------------------------------------------------
// allocate: a read state and a check state per 64-page word scanned (up to
//   all 16384 words), then a read/write pair per word of the run to mark it.
// free: a read/write pair per touched word. one transaction at a time.
// after reset a clearing pass writes all 16384 words of the map (page 0 used);
//   no request is taken until it ends.
`default_nettype none
module first_fit_page_bitmap_allocator_core (
   input  wire logic clock,
   input  wire logic reset,
   ffpba_req_if.sink   req,
   ffpba_rsp_if.source rsp
);
   import ffpba_pkg::*;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0]    waddr_ff, waddr_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [PAGE_W:0]      run_ff, run_in;      // free pages in current run
   logic [PAGE_W-1:0]    start_ff, start_in;  // first page of current run
   logic [PAGE_W:0]      cur_ff, cur_in;      // first page of the mark/free range
   logic [PAGE_W:0]      end_ff, end_in;      // one past last page
   rsp_type              rsp_ff, rsp_in;
   rsp_type              rsp_data_ff, rsp_data_in;  // result held on the channel
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 we;
   logic [ADDR_W-1:0]    ram_addr;
   logic [WORD_BITS-1:0] wdata, rdata;

   ffpba_map_ram u_ram (
      .clock(clock), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
   );

   // run length ending at each free bit, taken from the nearest used bit
   // below it; the lowest bit whose run reaches count_ff ends the search
   logic [WORD_BITS-1:0] any_used;
   logic [BIT_W-1:0]     last_used [WORD_BITS];
   logic [PAGE_W:0]      run_len [WORD_BITS];
   logic [PAGE_W-1:0]    run_start [WORD_BITS];
   logic [WORD_BITS-1:0] hit;
   logic              found;
   logic [PAGE_W-1:0] found_start;
   logic [PAGE_W:0]   run_w;
   logic [PAGE_W-1:0] start_w;
   always_comb begin
      any_used[0]  = rdata[0];
      last_used[0] = '0;
      for (int b = 1; b < WORD_BITS; b++) begin
         any_used[b]  = any_used[b-1] | rdata[b];
         last_used[b] = rdata[b] ? BIT_W'(b) : last_used[b-1];
      end
      for (int b = 0; b < WORD_BITS; b++) begin
         if (any_used[b]) begin
            run_len[b]   = (PAGE_W+1)'(BIT_W'(b) - last_used[b]);
            run_start[b] = {waddr_ff, last_used[b] + 1'b1};
         end else begin
            run_len[b]   = run_ff + (PAGE_W+1)'(b + 1);
            run_start[b] = (run_ff == '0) ? {waddr_ff, BIT_W'(0)} : start_ff;
         end
         hit[b] = !rdata[b] && (run_len[b] >= (PAGE_W+1)'(count_ff));
      end
      found       = |hit;
      found_start = '0;
      for (int b = WORD_BITS-1; b >= 0; b--) begin
         if (hit[b]) found_start = run_start[b];
      end
      run_w   = rdata[WORD_BITS-1] ? '0 : run_len[WORD_BITS-1];
      start_w = run_start[WORD_BITS-1];
   end

   // mask of bits in word waddr_ff lying in [cur_ff, end_ff)
   logic [WORD_BITS-1:0] mask;
   logic [PAGE_W:0]      word_base, word_next;
   always_comb begin
      word_base = {1'b0, waddr_ff, {BIT_W{1'b0}}};
      for (int b = 0; b < WORD_BITS; b++) begin
         mask[b] = ((word_base + (PAGE_W+1)'(b)) >= cur_ff) &&
                   ((word_base + (PAGE_W+1)'(b)) < end_ff);
      end
      word_next = word_base + (PAGE_W+1)'(WORD_BITS);
   end

   logic [PAGE_W+12:0] free_end_full;
   assign free_end_full = {1'b0, req.data.free_address[31:PAGE_SHIFT]}
                          + (PAGE_W+13)'(req.data.page_count);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (waddr_ff == ADDR_W'(MAP_WORDS-1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req.valid) begin
               if (req.data.cmd == CMD_FREE) state_in = ST_FREE_RD;
               else if (req.data.page_count == '0 ||
                        req.data.page_count > COUNT_W'(NUM_PAGES)) state_in = ST_RESP;
               else state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (found) state_in = ST_MARK_RD;
            else if (waddr_ff == ADDR_W'(MAP_WORDS-1)) state_in = ST_RESP;
            else state_in = ST_SCAN_RD;
         end
         ST_MARK_RD:  state_in = ST_MARK_WR;
         ST_MARK_WR:  state_in = (word_next >= end_ff) ? ST_RESP : ST_MARK_RD;
         ST_FREE_RD:  state_in = (cur_ff >= end_ff) ? ST_RESP : ST_FREE_WR;
         ST_FREE_WR:  state_in = (word_next >= end_ff) ? ST_RESP : ST_FREE_RD;
         ST_RESP:     if (!rsp_valid_ff || rsp.ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      waddr_in = waddr_ff; run_in = run_ff; start_in = start_ff;
      cur_in = cur_ff; end_in = end_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      we = 1'b0; wdata = '0; ram_addr = waddr_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            wdata = (waddr_ff == '0) ? WORD_BITS'(1) : '0;
            waddr_in = waddr_ff + 1'b1;
         end
         ST_IDLE: begin
            waddr_in = '0; run_in = '0; start_in = '0;
            rsp_in = '0;
            rsp_in.status = (req.data.cmd == CMD_ALLOC);
            cur_in = {1'b0, req.data.free_address[31:PAGE_SHIFT]};
            end_in = (free_end_full > (PAGE_W+13)'(NUM_PAGES)) ?
                     (PAGE_W+1)'(NUM_PAGES) : free_end_full[PAGE_W:0];
            if (req.data.cmd == CMD_FREE)
               waddr_in = req.data.free_address[31:PAGE_SHIFT+BIT_W];
         end
         ST_SCAN_RD: ;
         ST_SCAN_CHK: begin
            run_in = run_w; start_in = start_w;
            if (found) begin
               cur_in = {1'b0, found_start};
               end_in = {1'b0, found_start} + (PAGE_W+1)'(count_ff);
               waddr_in = found_start[PAGE_W-1:BIT_W];
               rsp_in.status = 1'b0;
               rsp_in.alloc_address = 32'(found_start) << PAGE_SHIFT;
            end else begin
               waddr_in = waddr_ff + 1'b1;
            end
         end
         ST_MARK_RD: ;
         ST_MARK_WR: begin
            we = 1'b1; wdata = rdata | mask;
            waddr_in = waddr_ff + 1'b1;
         end
         ST_FREE_RD: ;
         ST_FREE_WR: begin
            we = 1'b1; wdata = rdata & ~mask;
            waddr_in = waddr_ff + 1'b1;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rsp_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         waddr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         waddr_ff <= waddr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in; start_ff <= start_in;
      cur_ff <= cur_in; end_ff <= end_in; rsp_ff <= rsp_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_IDLE && req.valid) begin
         count_ff <= req.data.page_count;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
endmodule
`default_nettype wire

### rtl/core/ffpba_map_ram.sv
// ----------------------------------------------------------------------------
// ffpba_map_ram
// Single-port page bitmap memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffpba_map_ram (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [ffpba_pkg::ADDR_W-1:0]   addr,
   input  wire logic [ffpba_pkg::WORD_BITS-1:0] wdata,
   output      logic [ffpba_pkg::WORD_BITS-1:0] rdata
);
   import ffpba_pkg::*;
   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire
